FILE: rtl/scr_pkg.sv
package scr_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
    } out_t;

    typedef enum logic [1:0] {
        PR_NONE    = 2'd0,
        PR_BLANK   = 2'd1,
        PR_BLANK_I = 2'd2
    } pronoun_t;

    // results of one accepted byte: held byte first, then the flushed current byte
    typedef struct packed {
        logic valid0;
        out_t data0;
        logic valid1;
        out_t data1;
    } push_t;

    localparam logic [7:0] CH_PERIOD   = 8'h2E;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_LOWER_I  = 8'h69;
    localparam logic [7:0] CH_UPPER_I  = 8'h49;
    localparam logic [7:0] CASE_BIT    = 8'h20;

endpackage

FILE: rtl/scr_core.sv
module scr_core
    import scr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  in_t   in_data,
    output push_t push
);

    logic       ase_reg, ase_next;
    pronoun_t   pr_reg, pr_next;
    logic [7:0] held_char_reg, held_char_next;
    logic       held_valid_reg, held_valid_next;

    logic [7:0] c;
    logic [7:0] held_out;
    logic       is_upper, is_lower, is_letter, is_blank, is_end;

    always_comb
    begin
        is_upper  = in_data.char_in inside {[8'h41:8'h5A]};
        is_lower  = in_data.char_in inside {[8'h61:8'h7A]};
        is_letter = is_upper || is_lower;
        is_end    = in_data.char_in inside {CH_PERIOD, CH_QUESTION, CH_BANG};

        c        = in_data.char_in;
        ase_next = ase_reg;
        if (is_end)
        begin
            ase_next = 1'b1;
        end
        else if (is_letter)
        begin
            if (ase_reg && is_lower)
                c = in_data.char_in & ~CASE_BIT;
            else if (!ase_reg && is_upper)
                c = in_data.char_in | CASE_BIT;
            ase_next = 1'b0;
        end

        is_blank = (c == 8'h20) || (c inside {[8'h09:8'h0D]});

        held_out = held_char_reg;
        case (pr_reg)
            PR_BLANK:
            begin
                pr_next = (c == CH_LOWER_I) ? PR_BLANK_I : PR_NONE;
            end
            PR_BLANK_I:
            begin
                if (!is_letter)
                    held_out = CH_UPPER_I;
                pr_next = is_blank ? PR_BLANK : PR_NONE;
            end
            default:
            begin
                pr_next = is_blank ? PR_BLANK : PR_NONE;
            end
        endcase

        push.valid0         = held_valid_reg;
        push.data0.char_out = held_out;
        push.data0.last_out = 1'b0;
        push.valid1         = in_data.last_in;
        push.data1.char_out = c;
        push.data1.last_out = 1'b1;

        if (in_data.last_in)
        begin
            ase_next        = 1'b1;
            pr_next         = PR_NONE;
            held_char_next  = '0;
            held_valid_next = 1'b0;
        end
        else
        begin
            held_char_next  = c;
            held_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ase_reg        <= 1'b1;
            pr_reg         <= PR_NONE;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            ase_reg        <= ase_next;
            pr_reg         <= pr_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

FILE: rtl/scr_outq.sv
module scr_outq
    import scr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  push_t push,
    output logic  out_valid,
    input  logic  out_ready,
    output out_t  out_data
);

    logic [1:0] count_reg, count_next;
    out_t       slot0_reg, slot0_next;
    out_t       slot1_reg, slot1_next;
    logic       pop;
    logic       accept;

    always_comb
    begin
        out_valid = (count_reg != 2'd0);
        out_data  = slot0_reg;
        pop       = out_valid && out_ready;
        // room for two results once this cycle's transfer leaves
        in_ready  = (count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready);
        accept    = in_valid && in_ready;

        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (accept)
        begin
            count_next = {1'b0, push.valid0} + {1'b0, push.valid1};
            slot0_next = push.valid0 ? push.data0 : push.data1;
            slot1_next = push.data1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

FILE: rtl/sentence_case_restorer.sv
// sentence_case_restorer: recases an upper-case ASCII byte stream into sentence case.
// Input channel in_valid/in_ready/in_data carries one byte with its last flag;
// output channel out_valid/out_ready/out_data carries the rewritten bytes.
// Each byte is held back until the next byte arrives, because turning a lone
// 'i' into 'I' depends on the byte that follows. A byte therefore appears on the
// output in the cycle after the next input transfer. A transfer with last set
// releases both the held byte and the final byte, the final one marked last.
// Throughput is one byte per cycle while the receiver is ready; after a last byte
// the two-entry output queue holds two results, so input is refused while it drains.
// The recasing and pronoun logic sit between the state registers and the
// output queue registers, a single combinational pass.
// If the receiver stalls, the queue fills and in_ready drops; nothing is lost.
// Reset empties the queue and returns the case state to start of text (next
// letter capitalized), with no byte held. After a last byte the same state is
// restored, so the following byte opens a new text.
module sentence_case_restorer
    import scr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    push_t push;
    logic  accept;

    assign accept = in_valid && in_ready;

    scr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (in_data),
        .push    (push)
    );

    scr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .push      (push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
